// ----- rtl/cbss_pkg.sv -----
`default_nettype none

package cbss_pkg;

    localparam int SOURCE_DEPTH_DEF  = 256;
    localparam int PATTERN_DEPTH_DEF = 32;

    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_SOURCE  = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_SEARCH  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/cbss_if.sv -----
`default_nettype none

interface cbss_in_if import cbss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface cbss_res_if import cbss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflowed;

    modport source (output valid, output found, output position, output overflowed,
                    input ready);
    modport sink   (input valid, input found, input position, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/cbss_ram.sv -----
`default_nettype none

module cbss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/circular_buffer_substring_search_top.sv -----
`default_nettype none

// Circular-buffer substring search.
// Input channel i_in carries one word per handshake: mode selects append to the
// source store, append to the pattern store, or run a search; data_byte is the
// byte to append. Result channel o_res carries one word per search: found,
// position of the lowest matching start (source wraps around its loaded length)
// and overflowed, set when a byte was dropped on a full store since the last search.
// Load words return nothing; i_in.ready is high while idle, so loads stream
// back to back.
// A search holds i_in.ready low while it walks start positions and pattern bytes
// with one byte comparator: each comparison is a registered RAM read (READ), then
// a compare (CMP), at most SOURCE_DEPTH * PATTERN_DEPTH comparisons in all. An
// empty source or empty pattern skips the walk and goes straight to the result.
// The result sits in an output register; while the receiver stalls, loads keep
// being taken, and a later search stops at its result until the register frees.
// A search clears both counts and the overflow flag when its result is posted.
// Reset (synchronous, active low) empties both stores and clears the flag; store
// contents need no clearing because reads stay below the counts.
module circular_buffer_substring_search_top import cbss_pkg::*; #(
    parameter int SOURCE_DEPTH  = SOURCE_DEPTH_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cbss_in_if.sink     i_in,
    cbss_res_if.source  o_res
);

    // index and count widths
    localparam int SIW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
    localparam int SCW = $clog2(SOURCE_DEPTH + 1);
    localparam int PIW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PCW = $clog2(PATTERN_DEPTH + 1);

    t_state              r_state, n_state;
    logic [SCW-1:0]      r_scount, n_scount;
    logic [PCW-1:0]      r_pcount, n_pcount;
    logic                r_ovf, n_ovf;
    logic [SIW-1:0]      r_p, n_p;        // candidate start position
    logic [PIW-1:0]      r_j, n_j;        // pattern byte index
    logic [SIW-1:0]      r_idx, n_idx;    // source index of (p + j) mod count
    logic                r_res_found, n_res_found;
    logic [POS_W-1:0]    r_res_pos, n_res_pos;
    logic                r_res_ovf, n_res_ovf;

    logic                r_out_valid;
    logic                r_out_found;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_ovf;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_src_full;
    logic                w_pat_full;
    logic                w_src_we;
    logic                w_pat_we;
    logic [BYTE_W-1:0]   w_src_q;
    logic [BYTE_W-1:0]   w_pat_q;
    logic [PCW-1:0]      w_j_inc;
    logic [SCW-1:0]      w_idx_inc;
    logic [SCW-1:0]      w_p_inc;
    logic [SIW+POS_W-1:0] w_p_wide;
    t_mode               w_mode;

    assign w_mode     = t_mode'(i_in.mode);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_src_full = (r_scount >= SCW'(SOURCE_DEPTH));
    assign w_pat_full = (r_pcount >= PCW'(PATTERN_DEPTH));
    assign w_src_we   = w_in_acc && (w_mode == MODE_SOURCE) && !w_src_full;
    assign w_pat_we   = w_in_acc && (w_mode == MODE_PATTERN) && !w_pat_full;

    assign w_j_inc    = PCW'(r_j) + 1'b1;
    assign w_idx_inc  = SCW'(r_idx) + 1'b1;
    assign w_p_inc    = SCW'(r_p) + 1'b1;
    // position is reported modulo 256
    assign w_p_wide   = {{POS_W{1'b0}}, r_p};

    // Stores: write at the fill count, read at the walk indices.
    cbss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SOURCE_DEPTH),
        .AW    (SIW)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_src_we),
        .i_waddr (r_scount[SIW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (r_idx),
        .o_rdata (w_src_q)
    );

    cbss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PATTERN_DEPTH),
        .AW    (PIW)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_waddr (r_pcount[PIW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (r_j),
        .o_rdata (w_pat_q)
    );

    assign i_in.ready = (r_state == S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scount <= '0;
            r_pcount <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scount <= n_scount;
            r_pcount <= n_pcount;
            r_ovf    <= n_ovf;
        end
    end

    // Walk indices and pending result.
    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_j         <= n_j;
        r_idx       <= n_idx;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_res_ovf   <= n_res_ovf;
    end

    // Sequencer: one byte comparison per READ/CMP pair.
    always_comb begin
        n_state     = r_state;
        n_scount    = r_scount;
        n_pcount    = r_pcount;
        n_ovf       = r_ovf;
        n_p         = r_p;
        n_j         = r_j;
        n_idx       = r_idx;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_res_ovf   = r_res_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_mode)
                        MODE_SOURCE: begin
                            if (w_src_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_scount = r_scount + 1'b1;
                            end
                        end
                        MODE_PATTERN: begin
                            if (w_pat_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_pcount = r_pcount + 1'b1;
                            end
                        end
                        MODE_SEARCH: begin
                            n_res_ovf   = r_ovf;
                            n_res_found = 1'b0;
                            n_res_pos   = '0;
                            n_p         = '0;
                            n_j         = '0;
                            n_idx       = '0;
                            if (r_scount == '0) begin
                                // empty source never matches
                                n_state = S_RESULT;
                            end else if (r_pcount == '0) begin
                                // empty pattern matches at the start
                                n_res_found = 1'b1;
                                n_state     = S_RESULT;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: ;  // unused code: drop the word
                    endcase
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_src_q == w_pat_q) begin
                    if (w_j_inc == r_pcount) begin
                        n_res_found = 1'b1;
                        n_res_pos   = w_p_wide[POS_W-1:0];
                        n_state     = S_RESULT;
                    end else begin
                        n_j     = PIW'(w_j_inc);
                        n_idx   = (w_idx_inc == r_scount) ? '0 : SIW'(w_idx_inc);
                        n_state = S_READ;
                    end
                end else if (w_p_inc == r_scount) begin
                    n_state = S_RESULT;
                end else begin
                    n_p     = SIW'(w_p_inc);
                    n_j     = '0;
                    n_idx   = SIW'(w_p_inc);
                    n_state = S_READ;
                end
            end
            S_RESULT: begin
                // hold until the output register frees, then clear the loads
                if (w_out_free) begin
                    n_scount = '0;
                    n_pcount = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESULT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && w_out_free) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
            r_out_ovf   <= r_res_ovf;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out_found;
    assign o_res.position   = r_out_pos;
    assign o_res.overflowed = r_out_ovf;

    // Counts never run past their stores.
    a_scount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scount <= SCW'(SOURCE_DEPTH))
        else $error("source count beyond store depth");

    a_pcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= PCW'(PATTERN_DEPTH))
        else $error("pattern count beyond store depth");

    // Posting a result clears the loads and presents the word.
    a_post_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) && w_out_free |=>
            (r_scount == '0) && (r_pcount == '0) && !r_ovf && r_out_valid
            && (r_state == S_IDLE))
        else $error("result post did not clear state");

    // A search never starts a walk with an empty store.
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_scount != '0) && (r_pcount != '0))
        else $error("walk started on empty store");

endmodule

`default_nettype wire

// ----- tb/sv/circular_buffer_substring_search_top_test.sv -----
`default_nettype none

module circular_buffer_substring_search_top_test;
    import cbss_pkg::*;

    // Mode value 3 has no meaning for the block: it must swallow the word quietly.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam int SRC_DEPTH      = SOURCE_DEPTH_DEF;
    localparam int PAT_DEPTH      = PATTERN_DEPTH_DEF;
    localparam int WORD_TARGET    = 1050;    // non-reserved words to queue in all, directed ones included
    localparam int IDLE_PCT       = 12;      // chance per cycle that a side idles
    localparam int HOLD_AFTER     = 8;       // results taken before the long receiver stall
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 20;      // quiet cycles at the end to catch stray results
    // Longest legal silence: a full 256 x 32 search plus the receiver stall; take it
    // several times over.
    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
        bit                drain;   // hold this word back until no result is outstanding
    } t_word;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflowed;
    } t_result;

    logic clk = 1'b0;
    logic rst_n;

    cbss_in_if  in_if ();
    cbss_res_if res_if ();

    circular_buffer_substring_search_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: both stores, their fill counts and the
    // dropped-byte flag, advanced once per accepted input word.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] src_mem [SRC_DEPTH];
    logic [BYTE_W-1:0] pat_mem [PAT_DEPTH];
    int                src_len = 0;
    int                pat_len = 0;
    bit                bytes_dropped = 1'b0;

    t_result search_results_q [$];   // results still owed by the block
    t_word   stim_q [$];             // words waiting for the driver

    // These counters are shared between processes and only written with nonblocking
    // assignments so every reader sees the value from before the edge.
    int words_in        = 0;
    int results_seen    = 0;
    int pending_results = 0;

    int real_words   = 0;
    int total_words  = 0;
    int search_count = 0;
    int hit_count    = 0;
    int drop_count   = 0;
    int ignored      = 0;
    int err_count    = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_started = 1'b0;

    // Neither side idles at random through this window of the stream.
    logic steady;
    assign steady = (words_in >= 300) && (words_in < 550);

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // Apply one accepted word to the shadow state; return 1 if it owes a result.
    function automatic bit absorb_word(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data);
        t_result r;
        int      p;
        int      j;
        int      idx;
        bit      ok;
        case (mode)
            MODE_SOURCE: begin
                if (src_len < SRC_DEPTH) begin
                    src_mem[src_len] = data;
                    src_len++;
                end else begin
                    bytes_dropped = 1'b1;
                end
                return 1'b0;
            end
            MODE_PATTERN: begin
                if (pat_len < PAT_DEPTH) begin
                    pat_mem[pat_len] = data;
                    pat_len++;
                end else begin
                    bytes_dropped = 1'b1;
                end
                return 1'b0;
            end
            MODE_SEARCH: begin
                r = '0;
                r.overflowed = bytes_dropped;
                // Walk start positions upward; the source wraps at its loaded length.
                for (p = 0; p < src_len && !r.found; p++) begin
                    ok  = 1'b1;
                    idx = p;
                    for (j = 0; j < pat_len && ok; j++) begin
                        if (src_mem[idx] != pat_mem[j])
                            ok = 1'b0;
                        idx++;
                        if (idx >= src_len)
                            idx = 0;
                    end
                    if (ok) begin
                        r.found    = 1'b1;
                        r.position = p[POS_W-1:0];
                    end
                end
                search_results_q.push_back(r);
                search_count++;
                hit_count  += r.found;
                drop_count += r.overflowed;
                src_len       = 0;
                pat_len       = 0;
                bytes_dropped = 1'b0;
                return 1'b1;
            end
            default: begin
                ignored++;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_word(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                             input bit drain);
        t_word w;
        w.mode  = mode;
        w.data  = data;
        w.drain = drain;
        stim_q.push_back(w);
        if (mode != MODE_RESERVED)
            real_words++;
    endtask

    // Small alphabets around a random base give many near matches.
    function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] base, int alphabet);
        if (alphabet >= 256)
            return BYTE_W'($urandom_range(0, 255));
        return base ^ BYTE_W'($urandom_range(0, alphabet - 1));
    endfunction

    // One load-and-search sequence. With aim_hit the pattern is cut from the
    // stored source (wrapping) starting at start, or at a random spot if start < 0.
    task automatic add_sequence(input int n_src, input int n_pat, input bit aim_hit,
                                input int alphabet, input int start, input bit drain);
        logic [BYTE_W-1:0] src_b [$];
        logic [BYTE_W-1:0] pat_b [$];
        logic [BYTE_W-1:0] base;
        int                stored;
        int                s;
        int                i;
        int                k;
        bit                first;
        base  = BYTE_W'($urandom_range(0, 255));
        first = drain;
        for (i = 0; i < n_src; i++)
            src_b.push_back(pick_byte(base, alphabet));
        stored = (n_src < SRC_DEPTH) ? n_src : SRC_DEPTH;
        s = (start >= 0) ? start : ((stored > 0) ? $urandom_range(0, stored - 1) : 0);
        for (k = 0; k < n_pat; k++) begin
            if (aim_hit && stored > 0)
                pat_b.push_back(src_b[(s + k) % stored]);
            else
                pat_b.push_back(pick_byte(base, alphabet));
        end
        // Spoil one pattern byte now and then for a near miss.
        if (start < 0 && n_pat > 0 && $urandom_range(0, 3) == 0)
            pat_b[$urandom_range(0, n_pat - 1)] = pick_byte(base, alphabet);
        // Interleave the two load streams; they fill separate stores.
        i = 0;
        k = 0;
        while (i < n_src || k < n_pat) begin
            if (!first && $urandom_range(0, 39) == 0)
                push_word(MODE_RESERVED, BYTE_W'($urandom_range(0, 255)), 1'b0);
            if (k >= n_pat || (i < n_src && $urandom_range(0, 1) == 1)) begin
                push_word(MODE_SOURCE, src_b[i], first);
                i++;
            end else begin
                push_word(MODE_PATTERN, pat_b[k], first);
                k++;
            end
            first = 1'b0;
        end
        push_word(MODE_SEARCH, BYTE_W'($urandom_range(0, 255)), first);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next word once the current one is taken or none is up.
    // ------------------------------------------------------------------
    t_word next_word;

    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_if.valid || in_if.ready) begin
                if (stim_q.size() == 0 || (!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
                    in_if.valid <= 1'b0;
                end else if (stim_q[0].drain && (in_if.valid || pending_results != 0)) begin
                    // Pause the sender until every owed result has come back.
                    in_if.valid <= 1'b0;
                end else begin
                    next_word = stim_q.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.mode      <= next_word.mode;
                    in_if.data_byte <= next_word.data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off while the sender keeps
    // pushing so the result register fills and the input backs up.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (!hold_started && results_seen >= HOLD_AFTER) begin
                hold_started <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input word, check every result.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : observe
        t_result want;
        t_result got;
        int      took_in;
        int      owed;
        int      matched;
        if (rst_n) begin
            took_in = 0;
            owed    = 0;
            matched = 0;
            if (in_if.valid && in_if.ready) begin
                took_in = 1;
                owed    = absorb_word(in_if.mode, in_if.data_byte);
            end
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.found, res_if.position, res_if.overflowed};
                if (search_results_q.size() == 0) begin
                    note_mismatch($sformatf("result with none owed: found=%0d pos=%0d ovf=%0d",
                                            got.found, got.position, got.overflowed));
                end else begin
                    want    = search_results_q.pop_front();
                    matched = 1;
                    if (got.found !== want.found)
                        note_mismatch($sformatf("result %0d found: expected %0d, got %0d",
                                                results_seen, want.found, got.found));
                    if (got.position !== want.position)
                        note_mismatch($sformatf("result %0d position: expected %0d, got %0d",
                                                results_seen, want.position, got.position));
                    if (got.overflowed !== want.overflowed)
                        note_mismatch($sformatf("result %0d overflowed: expected %0d, got %0d",
                                                results_seen, want.overflowed,
                                                got.overflowed));
                end
            end
            words_in        <= words_in + took_in;
            results_seen    <= results_seen + matched;
            pending_results <= pending_results + owed - matched;
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles, %0d results owed",
                         idle_cycles, pending_results);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int  n_src;
        int  n_pat;
        int  kind;
        int  alpha;
        bit  drain_now;
        bit  drain_done;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_SOURCE;
        in_if.data_byte  = '0;
        res_if.ready     = 1'b0;
        drain_done       = 1'b0;

        // Search straight out of reset: both stores empty.
        push_word(MODE_SEARCH, 8'h00, 1'b0);
        // Empty pattern on a one-byte source: hit at 0.
        push_word(MODE_SOURCE, 8'h00, 1'b0);
        push_word(MODE_SEARCH, 8'hFF, 1'b0);
        // Empty source never matches.
        push_word(MODE_PATTERN, 8'hAA, 1'b0);
        push_word(MODE_SEARCH, 8'h00, 1'b0);
        // Reserved mode dropped mid-load; byte extremes in the source.
        push_word(MODE_SOURCE, 8'hFF, 1'b0);
        push_word(MODE_RESERVED, 8'h5A, 1'b0);
        push_word(MODE_SOURCE, 8'h00, 1'b0);
        push_word(MODE_PATTERN, 8'h00, 1'b0);
        push_word(MODE_SEARCH, 8'h00, 1'b0);
        // Match that wraps past the end of the source.
        push_word(MODE_SOURCE, 8'h12, 1'b0);
        push_word(MODE_SOURCE, 8'h34, 1'b0);
        push_word(MODE_SOURCE, 8'h56, 1'b0);
        push_word(MODE_PATTERN, 8'h56, 1'b0);
        push_word(MODE_PATTERN, 8'h12, 1'b0);
        push_word(MODE_SEARCH, 8'h00, 1'b0);
        // Pattern longer than the source, compared around and around.
        push_word(MODE_SOURCE, 8'h80, 1'b0);
        push_word(MODE_SOURCE, 8'h7F, 1'b0);
        push_word(MODE_PATTERN, 8'h7F, 1'b0);
        push_word(MODE_PATTERN, 8'h80, 1'b0);
        push_word(MODE_PATTERN, 8'h7F, 1'b0);
        push_word(MODE_PATTERN, 8'h80, 1'b0);
        push_word(MODE_PATTERN, 8'h7F, 1'b0);
        push_word(MODE_SEARCH, 8'h00, 1'b0);

        // Overfill both stores and aim the pattern at the last start position.
        add_sequence(SRC_DEPTH + 2, PAT_DEPTH + 2, 1'b1, 256, SRC_DEPTH - 1, 1'b1);

        // Random sequences: mostly short and well formed, some tiny or broken
        // ones, and an occasional full-size source.
        while (real_words < WORD_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                n_src = $urandom_range(SRC_DEPTH - 16, SRC_DEPTH + 14);
                n_pat = $urandom_range(1, PAT_DEPTH + 4);
            end else if (kind < 15) begin
                n_src = $urandom_range(0, 3);
                n_pat = $urandom_range(0, 4);
            end else begin
                n_src = $urandom_range(1, 20);
                n_pat = $urandom_range(0, 6);
            end
            alpha     = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
            drain_now = !drain_done && real_words >= 650;
            add_sequence(n_src, n_pat, $urandom_range(0, 99) < 70, alpha, -1, drain_now);
            if (drain_now)
                drain_done = 1'b1;
        end
        total_words = stim_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every owed result to come out.
        do
            @(posedge clk);
        while (words_in != total_words || pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (search_results_q.size() != 0) begin
            $display("%0d results never arrived", search_results_q.size());
            err_count += search_results_q.size();
        end
        $display("Ran %0d input words (%0d reserved-mode words ignored) through %0d searches",
                 words_in, ignored, search_count);
        $display("  %0d searches hit, %0d reported dropped bytes, %0d mismatches",
                 hit_count, drop_count, err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
